// ----- rtl/vshs_pkg.sv -----
// ----------------------------------------------------------------------------
// vshs_pkg
// Shared types and constants for the visited-state hash set.
// ----------------------------------------------------------------------------
package vshs_pkg;

	localparam int STEM_W  = 10;
	localparam int LAYER_W = 8;
	localparam int STEP_W  = 8;
	localparam int KEY_W   = STEM_W + LAYER_W + STEP_W;   // packed search-state key
	localparam int HASH_W  = 24;                          // layer at 16, step at 0, stem xor'd low

	typedef logic [KEY_W-1:0] key_t;

	// one slot of the table: occupancy flag plus stored key
	typedef struct packed {
		logic valid;
		key_t key;
	} slot_t;

	// control group from the sequencer to the slot table
	typedef struct packed {
		logic  rd_en;
		logic  wr_en;
		slot_t wr_data;
	} tbl_req_t;

	function automatic key_t pack_key(
		input logic [STEM_W-1:0]  stem,
		input logic [LAYER_W-1:0] layer,
		input logic [STEP_W-1:0]  step
	);
		return {stem, layer, step};
	endfunction

	function automatic logic [HASH_W-1:0] hash_of(
		input logic [STEM_W-1:0]  stem,
		input logic [LAYER_W-1:0] layer,
		input logic [STEP_W-1:0]  step
	);
		return {layer, 8'd0, step} ^ {14'd0, stem};
	endfunction

endpackage

// ----- rtl/vshs_slot_table.sv -----
// ----------------------------------------------------------------------------
// vshs_slot_table
// Single-port slot memory, one read or one write per cycle, registered read.
// ----------------------------------------------------------------------------
module vshs_slot_table import vshs_pkg::*; #(
	parameter int SLOTS = 256,
	parameter int IDX_W = 8
) (
	input  logic             clk,
	input  tbl_req_t         req,
	input  logic [IDX_W-1:0] addr,
	output slot_t            rd_data
);

	slot_t mem [SLOTS];
	slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/visited_state_hash_set.sv -----
// ----------------------------------------------------------------------------
// visited_state_hash_set
// Fixed-size linear-probing set of search-state keys. A probe transaction
// reports whether its key was already present, inserting it otherwise, and
// flags overflow when an insertion would lift occupancy above two thirds.
// A clear transaction empties the set.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | sink      | in_valid / in_stall | kind, stem_len, layer_state, step_count
//  out     | source    | out_valid/out_stall | seen, overflow
//
//  Probe: an accept state, then a read state and a compare state per slot examined,
//    then a response state that posts the result. The single port of the slot
//    table with its registered read is why each slot needs both a read and a compare.
//  Clear: a clearing pass over all SLOTS slots, one slot per cycle, then the result.
//  After reset the same clearing pass runs; in_stall is high for it.
//  One transaction at a time; a finished result sits in the output register
//    while the next transaction is taken, so out_stall only blocks a second result.
// ----------------------------------------------------------------------------
module visited_state_hash_set import vshs_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [STEM_W-1:0]  stem_len,
	input  logic [LAYER_W-1:0] layer_state,
	input  logic [STEP_W-1:0]  step_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               seen,
	output logic               overflow
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = IDX_W + 1;          // holds 0..SLOTS
	localparam int LIMIT = (2 * SLOTS) / 3;    // max occupancy after an insertion

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_RESP
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             clr_reply_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] probe_q;
	logic [CNT_W-1:0] used_q;
	key_t             key_q;
	logic             res_seen_q;
	logic             res_ovf_q;
	logic             out_valid_q;
	logic             seen_q;
	logic             overflow_q;

	tbl_req_t         tbl_req;
	logic [IDX_W-1:0] tbl_addr;
	slot_t            tbl_rd;

	logic [HASH_W+IDX_W-1:0] hash_wide;
	logic [IDX_W-1:0]        home_idx;
	logic                    limit_hit;
	logic                    key_hit;
	logic [CNT_W-1:0]        probe_next;

	// home slot: hash masked to the table size
	assign hash_wide  = {{IDX_W{1'b0}}, hash_of(stem_len, layer_state, step_count)};
	assign home_idx   = hash_wide[IDX_W-1:0];

	// one more key would pass two thirds of the table
	assign limit_hit  = (used_q >= CNT_W'(LIMIT));
	assign key_hit    = tbl_rd.valid && (tbl_rd.key == key_q);
	assign probe_next = probe_q + CNT_W'(1);

	// slot table access, driven by the sequencer state
	always_comb begin
		tbl_req  = '0;
		tbl_addr = idx_q;
		case (state_q)
			ST_CLEAR: begin
				tbl_req.wr_en = 1'b1;
				tbl_addr      = clr_idx_q;
			end
			ST_READ: begin
				tbl_req.rd_en = 1'b1;
			end
			ST_CMP: begin
				// empty slot under the limit takes the key
				if (!tbl_rd.valid && !limit_hit) begin
					tbl_req.wr_en         = 1'b1;
					tbl_req.wr_data.valid = 1'b1;
					tbl_req.wr_data.key   = key_q;
				end
			end
			default: begin
			end
		endcase
	end

	vshs_slot_table #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.req     (tbl_req),
		.addr    (tbl_addr),
		.rd_data (tbl_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			clr_reply_q <= 1'b0;
			idx_q       <= '0;
			probe_q     <= '0;
			used_q      <= '0;
			key_q       <= '0;
			res_seen_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
			seen_q      <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			// result taken downstream; the response state handles its own reload
			if (out_valid_q && !out_stall && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == {IDX_W{1'b1}}) begin
						used_q     <= '0;
						res_seen_q <= 1'b0;
						res_ovf_q  <= 1'b0;
						state_q    <= clr_reply_q ? ST_RESP : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (kind) begin
							clr_idx_q   <= '0;
							clr_reply_q <= 1'b1;
							state_q     <= ST_CLEAR;
						end else begin
							key_q   <= pack_key(stem_len, layer_state, step_count);
							idx_q   <= home_idx;
							probe_q <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!tbl_rd.valid) begin
						res_seen_q <= 1'b0;
						res_ovf_q  <= limit_hit;
						if (!limit_hit) begin
							used_q <= used_q + CNT_W'(1);
						end
						state_q <= ST_RESP;
					end else if (key_hit) begin
						res_seen_q <= 1'b1;
						res_ovf_q  <= 1'b0;
						state_q    <= ST_RESP;
					end else if (probe_next == CNT_W'(SLOTS)) begin
						// whole table scanned without a free slot
						res_seen_q <= 1'b0;
						res_ovf_q  <= 1'b1;
						state_q    <= ST_RESP;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						probe_q <= probe_next;
						state_q <= ST_READ;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						seen_q      <= res_seen_q;
						overflow_q  <= res_ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign seen      = seen_q;
	assign overflow  = overflow_q;

	// occupancy never passes the load limit
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(LIMIT))
		else $error("occupancy above load limit");

	// a result is never both seen and overflow
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(seen_q && overflow_q))
		else $error("seen and overflow both set");

	// one transaction at a time: an accepted item blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while busy");

	// clearing pass only writes empty slots
	a_clear_writes_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (tbl_req.wr_en && !tbl_req.wr_data.valid))
		else $error("clearing pass wrote an occupied slot");

endmodule
